[hw/rtl/pfc_pkg.sv]
// Package: Playfair unit types, constants and small lookup functions.
package pfc_pkg;

  localparam int unsigned LETTER_COUNT = 26;
  localparam int unsigned CELL_COUNT   = 25;
  localparam int unsigned SIDE         = 5;

  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_X = 5'd23;
  localparam logic [4:0] LAST_LETTER = 5'(LETTER_COUNT - 1);
  localparam logic [4:0] CELLS = 5'(CELL_COUNT);
  localparam logic [4:0] LETTERS = 5'(LETTER_COUNT);

  localparam logic [1:0] KIND_KEY  = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_TEXT = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  localparam logic MODE_ENC = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FILL,
    ST_RD_A,
    ST_RD_B,
    ST_LOOK,
    ST_RD_X,
    ST_RD_Y,
    ST_CAP_Y,
    ST_SEND0,
    ST_SEND1
  } ctl_state_t;

  typedef struct packed {
    logic latch_item;
    logic place;
    logic fill_start;
    logic fill_step;
    logic set_pending;
    logic load_pair;
    logic pair_pad;
    logic pend_keep;
    logic pos_rd_b;
    logic cap_pa;
    logic cap_pb;
    logic sq_rd_y;
    logic cap_x;
    logic cap_y;
    logic load_out;
    logic out_last;
  } pfc_cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        letter_ok;
    logic        pend_valid;
    logic        same_letter;
    logic        fill_done;
    logic        out_free;
    logic [4:0]  fill_count;
    logic [25:0] used;
  } pfc_stat_t;

  // row of a cell index 0..24
  function automatic logic [2:0] pos_row(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic logic [2:0] pos_col(input logic [4:0] p);
    logic [2:0] r;
    logic [4:0] base;
    r = pos_row(p);
    base = ({2'b00, r} << 2) + {2'b00, r};
    return 3'(p - base);
  endfunction

  // step one place around a row or column, forward or back
  function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic back);
    logic [2:0] r;
    if (back) r = (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
    else      r = (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
    return r;
  endfunction

  function automatic logic [4:0] cell_index(input logic [2:0] row, input logic [2:0] col);
    return ({2'b00, row} << 2) + {2'b00, row} + {2'b00, col};
  endfunction

endpackage

[hw/rtl/pfc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/pfc_ctrl.sv]
// Controller state machine for the Playfair unit.
module pfc_ctrl import pfc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  logic      mode,
  input  pfc_stat_t stat,
  output pfc_cmd_t  cmd,
  output logic      idle
);

  ctl_state_t state, state_next;
  logic doubled;

  assign doubled = (mode == MODE_ENC) && stat.same_letter;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (stat.kind)
          KIND_KEY:  state_next = ST_IDLE;
          KIND_DONE: state_next = ST_FILL;
          KIND_TEXT: begin
            if (stat.letter_ok && stat.pend_valid) state_next = ST_RD_A;
            else state_next = ST_IDLE;
          end
          KIND_END: begin
            state_next = stat.pend_valid ? ST_RD_A : ST_IDLE;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_FILL: begin
        if (stat.fill_done) state_next = ST_IDLE;
      end
      ST_RD_A:  state_next = ST_RD_B;
      ST_RD_B:  state_next = ST_LOOK;
      ST_LOOK:  state_next = ST_RD_X;
      ST_RD_X:  state_next = ST_RD_Y;
      ST_RD_Y:  state_next = ST_CAP_Y;
      ST_CAP_Y: state_next = ST_SEND0;
      ST_SEND0: begin
        if (stat.out_free) state_next = ST_SEND1;
      end
      ST_SEND1: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    case (state)
      ST_IDLE: begin
        idle = 1'b1;
        cmd.latch_item = accept;
      end
      ST_DECODE: begin
        case (stat.kind)
          KIND_KEY:  cmd.place = 1'b1;
          KIND_DONE: cmd.fill_start = 1'b1;
          KIND_TEXT: begin
            if (stat.letter_ok) begin
              if (!stat.pend_valid) begin
                cmd.set_pending = 1'b1;
              end else begin
                cmd.load_pair = 1'b1;
                cmd.pair_pad  = doubled;
                cmd.pend_keep = doubled;
              end
            end
          end
          KIND_END: begin
            cmd.load_pair = stat.pend_valid;
            cmd.pair_pad  = 1'b1;
          end
          default: cmd = '0;
        endcase
      end
      ST_FILL:  cmd.fill_step = 1'b1;
      ST_RD_A:  cmd.pos_rd_b = 1'b0;
      ST_RD_B: begin
        cmd.pos_rd_b = 1'b1;
        cmd.cap_pa   = 1'b1;
      end
      ST_LOOK:  cmd.cap_pb = 1'b1;
      ST_RD_X:  cmd.sq_rd_y = 1'b0;
      ST_RD_Y: begin
        cmd.sq_rd_y = 1'b1;
        cmd.cap_x   = 1'b1;
      end
      ST_CAP_Y: begin
        cmd.sq_rd_y = 1'b1;
        cmd.cap_y   = 1'b1;
      end
      ST_SEND0: cmd.load_out = stat.out_free;
      ST_SEND1: begin
        cmd.load_out = stat.out_free;
        cmd.out_last = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[hw/rtl/pfc_datapath.sv]
// Datapath: key square and position memories, pending letter, digraph rules, output register.
module pfc_datapath import pfc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  pfc_cmd_t  cmd,
  input  logic      mode,
  input  logic [1:0] kind,
  input  logic [4:0] letter,
  input  logic      out_stall,
  output pfc_stat_t stat,
  output logic      out_valid,
  output logic [4:0] out_letter,
  output logic      last
);

  logic [1:0]  kind_q;
  logic [4:0]  letter_q;
  logic [25:0] used;
  logic [4:0]  fill_count;
  logic [4:0]  fill_c;
  logic        pend_valid;
  logic [4:0]  pend_letter;
  logic [4:0]  a_q, b_q, pa, pb, x_q, y_q;

  logic        letter_ok;
  logic        place_go, place_ok;
  logic [4:0]  place_v;
  logic [4:0]  pos_raddr, pos_rdata;
  logic [4:0]  sq_raddr, sq_rdata;
  logic [2:0]  r1, c1, r2, c2;
  logic [4:0]  x_idx, y_idx;
  logic        out_free;

  assign letter_ok = letter_q < LETTERS;

  assign place_v  = cmd.fill_step ? fill_c : letter_q;
  assign place_go = (cmd.place && letter_ok) || (cmd.fill_step && fill_c != LETTER_J);
  assign place_ok = place_go && !used[place_v] && (fill_count < CELLS);

  assign pos_raddr = cmd.pos_rd_b ? b_q : a_q;

  pfc_ram #(.WIDTH(5), .DEPTH(LETTER_COUNT)) u_pos_ram (
    .clk   (clk),
    .we    (place_ok),
    .waddr (place_v),
    .wdata (fill_count),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  pfc_ram #(.WIDTH(5), .DEPTH(CELL_COUNT)) u_sq_ram (
    .clk   (clk),
    .we    (place_ok),
    .waddr (fill_count),
    .wdata (place_v),
    .raddr (sq_raddr),
    .rdata (sq_rdata)
  );

  // digraph rules on the two cell positions
  always_comb begin
    r1 = pos_row(pa);
    c1 = pos_col(pa);
    r2 = pos_row(pb);
    c2 = pos_col(pb);
    if (r1 == r2) begin
      x_idx = cell_index(r1, wrap_step(c1, mode));
      y_idx = cell_index(r2, wrap_step(c2, mode));
    end else if (c1 == c2) begin
      x_idx = cell_index(wrap_step(r1, mode), c1);
      y_idx = cell_index(wrap_step(r2, mode), c2);
    end else begin
      x_idx = cell_index(r1, c2);
      y_idx = cell_index(r2, c1);
    end
  end

  assign sq_raddr = cmd.sq_rd_y ? y_idx : x_idx;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      used        <= '0;
      fill_count  <= '0;
      fill_c      <= '0;
      pend_valid  <= 1'b0;
      pend_letter <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (place_ok) begin
        used[place_v] <= 1'b1;
        fill_count    <= fill_count + 5'd1;
      end
      if (cmd.fill_start)     fill_c <= '0;
      else if (cmd.fill_step) fill_c <= fill_c + 5'd1;
      if (cmd.set_pending) begin
        pend_valid  <= 1'b1;
        pend_letter <= letter_q;
      end else if (cmd.load_pair) begin
        if (cmd.pend_keep) begin
          pend_letter <= letter_q;
        end else begin
          pend_valid  <= 1'b0;
          pend_letter <= '0;
        end
      end
      if (cmd.load_out)      out_valid <= 1'b1;
      else if (!out_stall)   out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      kind_q   <= kind;
      letter_q <= (letter == LETTER_J) ? LETTER_I : letter;
    end
    if (cmd.load_pair) begin
      a_q <= pend_letter;
      b_q <= cmd.pair_pad ? LETTER_X : letter_q;
    end
    // letters not yet placed sit at cell 0
    if (cmd.cap_pa) pa <= used[a_q] ? pos_rdata : '0;
    if (cmd.cap_pb) pb <= used[b_q] ? pos_rdata : '0;
    // unfilled cells read as letter 0
    if (cmd.cap_x)  x_q <= (x_idx < fill_count) ? sq_rdata : '0;
    if (cmd.cap_y)  y_q <= (y_idx < fill_count) ? sq_rdata : '0;
    if (cmd.load_out) begin
      out_letter <= cmd.out_last ? y_q : x_q;
      last       <= cmd.out_last;
    end
  end

  always_comb begin
    stat.kind        = kind_q;
    stat.letter_ok   = letter_ok;
    stat.pend_valid  = pend_valid;
    stat.same_letter = letter_q == pend_letter;
    stat.fill_done   = fill_c == LAST_LETTER;
    stat.out_free    = out_free;
    stat.fill_count  = fill_count;
    stat.used        = used;
  end

endmodule

[hw/rtl/playfair_digraph_cipher_unit.sv]
// Top level of the Playfair digraph cipher unit.
// Input words (kind, letter) arrive on in_valid/in_stall; result words
// (out_letter, last) leave on out_valid/out_stall. A word moves on a clock edge
// with valid high and stall low. Mode (0 encrypt, 1 decrypt) is written over
// the APB port at address 0 by the user while idle; the unit does not enforce it.
// One item is in work at a time; in_stall is low only when the controller idles.
// Steps per item, from accept back to idle:
//   key letter, dropped text letter, first letter of a pair: decode
//   key done: fill, one alphabet letter tried per cycle, 26 steps
//   digraph: two position memory reads, two key square reads, two sends;
//   the first result word is loaded in ST_SEND0, the second in ST_SEND1.
// A single output register holds each word; a stalled receiver holds the word
// there and the controller waits before loading the next one. A new item may be
// accepted while the second word of a digraph still waits in that register.
// Reset (synchronous, rst high) empties the key square, the pending letter and
// the output register and sets encrypt mode. The memories need no clearing:
// a fill count and a letter-used bit per letter mark their valid entries.
module playfair_digraph_cipher_unit import pfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [4:0]  letter,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_letter,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pfc_cmd_t  cmd;
  pfc_stat_t stat;
  logic      idle;
  logic      accept;
  logic      mode;

  assign in_stall = !idle;
  assign accept   = in_valid && !in_stall;
  assign pready   = 1'b1;
  assign prdata   = paddr[2] ? 32'd0 : {31'd0, mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENC;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      mode <= pwdata[0];
    end
  end

  pfc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .mode   (mode),
    .stat   (stat),
    .cmd    (cmd),
    .idle   (idle)
  );

  pfc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .mode       (mode),
    .kind       (kind),
    .letter     (letter),
    .out_stall  (out_stall),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_letter (out_letter),
    .last       (last)
  );

  a_used_matches_fill: assert property (@(posedge clk) disable iff (rst)
    $countones(stat.used) == stat.fill_count)
    else $error("letter-used bits disagree with fill count");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    stat.fill_count <= CELLS)
    else $error("key square overfilled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("accepted item not held busy");

  a_second_word: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && cmd.out_last) |=> (out_valid && last))
    else $error("second digraph word not presented");

endmodule
